@@ hw/rtl/ria_pkg.sv @@
`timescale 1ns / 1ps
package ria_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int XLEN           = 64;
    localparam int WORD_W         = 32;
    localparam int SHAMT_W        = 6;
    localparam int SHAMT_W_WORD   = 5;

    // request classes
    localparam logic [2:0] REQ_REG    = 3'd0;
    localparam logic [2:0] REQ_IMM    = 3'd1;
    localparam logic [2:0] REQ_WREG   = 3'd2;
    localparam logic [2:0] REQ_WIMM   = 3'd3;
    localparam logic [2:0] REQ_BRANCH = 3'd4;

    // funct3, ALU group
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3, branch group
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [6:0] F7_BASE     = 7'h00;
    localparam logic [6:0] F7_ALT      = 7'h20;
    localparam logic [6:0] F7_MD       = 7'h01;
    localparam logic [6:0] F7_IMM_MASK = 7'h7e;

    typedef enum logic [2:0] {
        K_NONE,
        K_SIMPLE,
        K_MUL,
        K_MULH,
        K_DIV,
        K_REM
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  word;
        logic  illegal;
        logic  taken;
    } t_ctrl;

    typedef struct packed {
        logic negq;
        logic negr;
        logic div0;
    } t_div_flags;

endpackage

@@ hw/rtl/ria_if.sv @@
`timescale 1ns / 1ps
interface ria_req_if;
    import ria_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [XLEN-1:0]   operand_a;
    logic [XLEN-1:0]   operand_b;
    logic [2:0]        funct3;
    logic [6:0]        funct7;

    modport source (output valid, req_type, operand_a, operand_b, funct3, funct7,
                    input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, funct3, funct7,
                    output ready);
endinterface

interface ria_rsp_if;
    import ria_pkg::*;
    logic              valid;
    logic              ready;
    logic [XLEN-1:0]   result;
    logic              branch_taken;
    logic              illegal_code;

    modport source (output valid, result, branch_taken, illegal_code, input ready);
    modport sink   (input valid, result, branch_taken, illegal_code, output ready);
endinterface

@@ hw/rtl/ria_decode.sv @@
`timescale 1ns / 1ps
module ria_decode #(
    parameter int DATA_WIDTH = ria_pkg::DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2:0]              i_req_type,
    input  logic [ria_pkg::XLEN-1:0] i_a,
    input  logic [ria_pkg::XLEN-1:0] i_b,
    input  logic [2:0]              i_funct3,
    input  logic [6:0]              i_funct7,
    output logic                    o_valid,
    output ria_pkg::t_ctrl          o_ctrl,
    output logic [DATA_WIDTH-1:0]   o_simple,
    output logic [ria_pkg::XLEN-1:0] o_ma,
    output logic [ria_pkg::XLEN-1:0] o_mb,
    output logic [DATA_WIDTH-1:0]   o_da,
    output logic [DATA_WIDTH-1:0]   o_db
);
    import ria_pkg::*;

    localparam int W = DATA_WIDTH;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_XOR, ALU_SRL, ALU_SRA,
        ALU_OR, ALU_AND, ALU_MUL, ALU_MULH, ALU_DIV, ALU_REM, ALU_ILL
    } t_alu;

    t_alu                 op;
    logic [6:0]           f7e;
    logic                 word;
    logic                 bad;
    logic                 branch;
    logic                 taken;
    logic                 br_bad;
    logic [W-1:0]         a_w;
    logic [W-1:0]         b_w;
    logic [WORD_W-1:0]    a32;
    logic [WORD_W-1:0]    b32;
    logic [WORD_W-1:0]    w_res;
    logic [SHAMT_W-1:0]   sh;
    logic [SHAMT_W_WORD-1:0] shw;
    logic [W-1:0]         n_simple;
    t_ctrl                n_ctrl;

    assign a_w = i_a[W-1:0];
    assign b_w = i_b[W-1:0];
    assign a32 = i_a[WORD_W-1:0];
    assign b32 = i_b[WORD_W-1:0];
    assign sh  = i_b[SHAMT_W-1:0];
    assign shw = i_b[SHAMT_W_WORD-1:0];

    // class-specific funct7 handling
    always_comb begin
        f7e    = i_funct7;
        word   = 1'b0;
        bad    = 1'b0;
        branch = 1'b0;
        unique case (i_req_type)
            REQ_REG: begin
                f7e = i_funct7;
            end
            REQ_IMM: begin
                // shamt[5] sits in funct7 bit 0
                f7e = (i_funct3 == F3_SLL || i_funct3 == F3_SRL) ?
                      (i_funct7 & F7_IMM_MASK) : F7_BASE;
            end
            REQ_WREG: begin
                word = 1'b1;
            end
            REQ_WIMM: begin
                word = 1'b1;
                if (i_funct3 == F3_ADD) begin
                    f7e = F7_BASE;
                end else if (i_funct3 != F3_SLL && i_funct3 != F3_SRL) begin
                    bad = 1'b1;
                end
            end
            REQ_BRANCH: begin
                branch = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        op = ALU_ILL;
        unique case (f7e)
            F7_BASE: begin
                unique case (i_funct3)
                    F3_ADD:  op = ALU_ADD;
                    F3_SLL:  op = ALU_SLL;
                    F3_SLT:  op = ALU_SLT;
                    F3_XOR:  op = ALU_XOR;
                    F3_SRL:  op = ALU_SRL;
                    F3_OR:   op = ALU_OR;
                    F3_AND:  op = ALU_AND;
                    default: op = ALU_ILL;
                endcase
            end
            F7_ALT: begin
                unique case (i_funct3)
                    F3_ADD:  op = ALU_SUB;
                    F3_SRL:  op = ALU_SRA;
                    default: op = ALU_ILL;
                endcase
            end
            F7_MD: begin
                unique case (i_funct3)
                    F3_ADD:  op = ALU_MUL;
                    F3_SLL:  op = ALU_MULH;
                    F3_XOR:  op = ALU_DIV;
                    F3_OR:   op = ALU_REM;
                    default: op = ALU_ILL;
                endcase
            end
            default: op = ALU_ILL;
        endcase
        if (word && !(op inside {ALU_ADD, ALU_SUB, ALU_SLL, ALU_SRL, ALU_SRA,
                                 ALU_MUL, ALU_DIV, ALU_REM})) begin
            op = ALU_ILL;
        end
        if (bad || branch) begin
            op = ALU_ILL;
        end
    end

    always_comb begin
        taken  = 1'b0;
        br_bad = 1'b0;
        unique case (i_funct3)
            F3_BEQ:  taken = (a_w == b_w);
            F3_BNE:  taken = (a_w != b_w);
            F3_BLT:  taken = ($signed(a_w) < $signed(b_w));
            F3_BGE:  taken = !($signed(a_w) < $signed(b_w));
            F3_BLTU: taken = (a_w < b_w);
            F3_BGEU: taken = (a_w >= b_w);
            default: br_bad = 1'b1;
        endcase
    end

    always_comb begin
        w_res = '0;
        case (op)
            ALU_ADD: w_res = a32 + b32;
            ALU_SUB: w_res = a32 - b32;
            ALU_SLL: w_res = a32 << shw;
            ALU_SRL: w_res = a32 >> shw;
            ALU_SRA: w_res = $signed(a32) >>> shw;
            default: w_res = '0;
        endcase
    end

    always_comb begin
        n_simple = '0;
        if (word) begin
            n_simple = W'($signed(w_res));
        end else begin
            case (op)
                ALU_ADD: n_simple = a_w + b_w;
                ALU_SUB: n_simple = a_w - b_w;
                ALU_SLL: n_simple = a_w << sh;
                ALU_SLT: n_simple = W'($signed(a_w) < $signed(b_w));
                ALU_XOR: n_simple = a_w ^ b_w;
                ALU_SRL: n_simple = a_w >> sh;
                ALU_SRA: n_simple = $signed(a_w) >>> sh;
                ALU_OR:  n_simple = a_w | b_w;
                ALU_AND: n_simple = a_w & b_w;
                default: n_simple = '0;
            endcase
        end
    end

    always_comb begin
        n_ctrl.word = word;
        n_ctrl.taken = branch && !br_bad && taken;
        n_ctrl.illegal = branch ? br_bad : (op == ALU_ILL);
        case (op)
            ALU_MUL:  n_ctrl.kind = K_MUL;
            ALU_MULH: n_ctrl.kind = K_MULH;
            ALU_DIV:  n_ctrl.kind = K_DIV;
            ALU_REM:  n_ctrl.kind = K_REM;
            ALU_ILL:  n_ctrl.kind = K_NONE;
            default:  n_ctrl.kind = K_SIMPLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctrl   <= n_ctrl;
            o_simple <= n_simple;
            o_ma     <= word ? XLEN'($signed(a32)) : XLEN'($signed(a_w));
            o_mb     <= word ? XLEN'($signed(b32)) : XLEN'($signed(b_w));
            o_da     <= word ? W'($signed(a32)) : a_w;
            o_db     <= word ? W'($signed(b32)) : b_w;
        end
    end

endmodule

@@ hw/rtl/ria_mul.sv @@
`timescale 1ns / 1ps
module ria_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ria_pkg::XLEN-1:0]  i_a,
    input  logic [ria_pkg::XLEN-1:0]  i_b,
    output logic [2*ria_pkg::XLEN-1:0] o_prod
);
    import ria_pkg::*;

    localparam int H = XLEN / 2;

    // stage 1: four half-width partial products
    logic [XLEN-1:0]   r_ll, r_lh, r_hl, r_hh;
    logic [XLEN-1:0]   r_a1, r_b1;
    // stage 2: unsigned product and signed correction
    logic [2*XLEN-1:0] r_sum;
    logic [XLEN-1:0]   r_corr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[H-1:0] * i_b[H-1:0];
            r_lh <= i_a[H-1:0] * i_b[XLEN-1:H];
            r_hl <= i_a[XLEN-1:H] * i_b[H-1:0];
            r_hh <= i_a[XLEN-1:H] * i_b[XLEN-1:H];
            r_a1 <= i_a;
            r_b1 <= i_b;

            r_sum  <= {r_hh, r_ll}
                    + ((2*XLEN)'(r_lh) << H)
                    + ((2*XLEN)'(r_hl) << H);
            r_corr <= (r_a1[XLEN-1] ? r_b1 : '0) + (r_b1[XLEN-1] ? r_a1 : '0);

            o_prod <= {r_sum[2*XLEN-1:XLEN] - r_corr, r_sum[XLEN-1:0]};
        end
    end

endmodule

@@ hw/rtl/ria_div.sv @@
`timescale 1ns / 1ps
module ria_div #(
    parameter int DATA_WIDTH = ria_pkg::DATA_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [DATA_WIDTH-1:0]  i_a,
    input  logic [DATA_WIDTH-1:0]  i_b,
    output logic [DATA_WIDTH-1:0]  o_quo,
    output logic [DATA_WIDTH-1:0]  o_rem,
    output ria_pkg::t_div_flags    o_flags
);
    import ria_pkg::*;

    localparam int W = DATA_WIDTH;

    // stage 0 holds magnitudes, stage k the state after k quotient bits
    logic [W-1:0] r_rem [0:W];
    logic [W-1:0] r_quo [0:W];
    logic [W-1:0] r_dvs [0:W];
    t_div_flags   r_fl  [0:W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]     <= '0;
            r_quo[0]     <= i_a[W-1] ? (W'(0) - i_a) : i_a;
            r_dvs[0]     <= i_b[W-1] ? (W'(0) - i_b) : i_b;
            r_fl[0].negq <= i_a[W-1] ^ i_b[W-1];
            r_fl[0].negr <= i_a[W-1];
            r_fl[0].div0 <= (i_b == '0);
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;

        assign trial = {r_rem[k-1], r_quo[k-1][W-1]};
        assign diff  = trial - {1'b0, r_dvs[k-1]};
        assign ge    = !diff[W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[W-1:0] : trial[W-1:0];
                r_quo[k] <= {r_quo[k-1][W-2:0], ge};
                r_dvs[k] <= r_dvs[k-1];
                r_fl[k]  <= r_fl[k-1];
            end
        end
    end

    assign o_quo   = r_quo[W];
    assign o_rem   = r_rem[W];
    assign o_flags = r_fl[W];

endmodule

@@ hw/rtl/rv64im_integer_alu_core.sv @@
`timescale 1ns / 1ps
// RV64IM execute unit, fully pipelined: one item may enter every clock in which
// the pipe advances, and each item's result leaves through the decode register,
// one magnitude stage and DATA_WIDTH one-bit stages of the restoring divider and
// the output register; the divider's depth sets the latency of every operation
// so that results leave in order. The whole pipe moves as
// one: it advances whenever the output register is empty or being taken, and
// i_req.ready follows that, so nothing is dropped or repeated under stalls.
// The 64x64 signed multiply runs as four 32x32 partial products over three
// stages. Word forms compute on the low 32 bits and sign-extend the result.
// Branch compares give result 0 plus branch_taken; unsupported codes give
// result 0 with illegal_code set.
module rv64im_integer_alu_core #(
    parameter int DATA_WIDTH = ria_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ria_req_if.sink    i_req,
    ria_rsp_if.source  o_rsp
);
    import ria_pkg::*;

    localparam int W = DATA_WIDTH;

    logic                en;

    // stage 0, decode
    logic                dec_valid;
    t_ctrl               dec_ctrl;
    logic [W-1:0]        dec_simple;
    logic [XLEN-1:0]     dec_ma;
    logic [XLEN-1:0]     dec_mb;
    logic [W-1:0]        dec_da;
    logic [W-1:0]        dec_db;

    // side line carrying control and simple result alongside the divider
    logic [W+1:1]        r_vld;
    t_ctrl               r_ctl [1:W+1];
    logic [W-1:0]        r_smp [1:W+1];

    // multiplier result, delayed from stage 3 up to the divider output
    logic [2*XLEN-1:0]   mul_prod;
    logic [W-1:0]        mul_sel;
    logic [W-1:0]        r_mdly [4:W+1];

    logic [W-1:0]        div_uq;
    logic [W-1:0]        div_ur;
    t_div_flags          div_fl;
    logic [W-1:0]        div_q;
    logic [W-1:0]        div_r;

    t_ctrl               tail_ctl;
    logic [W-1:0]        n_res;

    logic                r_out_valid;
    logic [W-1:0]        r_res;
    logic                r_taken;
    logic                r_ill;

    // pipe advances when the output slot is free or being emptied
    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    ria_decode #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_a        (i_req.operand_a),
        .i_b        (i_req.operand_b),
        .i_funct3   (i_req.funct3),
        .i_funct7   (i_req.funct7),
        .o_valid    (dec_valid),
        .o_ctrl     (dec_ctrl),
        .o_simple   (dec_simple),
        .o_ma       (dec_ma),
        .o_mb       (dec_mb),
        .o_da       (dec_da),
        .o_db       (dec_db)
    );

    ria_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (dec_ma),
        .i_b    (dec_mb),
        .o_prod (mul_prod)
    );

    ria_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_a     (dec_da),
        .i_b     (dec_db),
        .o_quo   (div_uq),
        .o_rem   (div_ur),
        .o_flags (div_fl)
    );

    // valid bits travel with the side line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[W:1], dec_valid};
        end
    end

    // mul low half (word: sign-extended low 32) or high half
    always_comb begin
        if (r_ctl[3].word) begin
            mul_sel = W'($signed(mul_prod[WORD_W-1:0]));
        end else if (r_ctl[3].kind == K_MULH) begin
            mul_sel = mul_prod[2*W-1:W];
        end else begin
            mul_sel = mul_prod[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[1] <= dec_ctrl;
            r_smp[1] <= dec_simple;
            for (int k = 2; k <= W + 1; k++) begin
                r_ctl[k] <= r_ctl[k-1];
                r_smp[k] <= r_smp[k-1];
            end
            r_mdly[4] <= mul_sel;
            for (int k = 5; k <= W + 1; k++) begin
                r_mdly[k] <= r_mdly[k-1];
            end
        end
    end

    // sign fix-up; overflow falls out of the magnitude path, zero divisor
    // needs the all-ones quotient forced (remainder is already the dividend)
    assign tail_ctl = r_ctl[W+1];
    assign div_q = div_fl.div0 ? '1 : (div_fl.negq ? (W'(0) - div_uq) : div_uq);
    assign div_r = div_fl.negr ? (W'(0) - div_ur) : div_ur;

    always_comb begin
        unique case (tail_ctl.kind)
            K_NONE:   n_res = '0;
            K_SIMPLE: n_res = r_smp[W+1];
            K_MUL:    n_res = r_mdly[W+1];
            K_MULH:   n_res = r_mdly[W+1];
            K_DIV:    n_res = tail_ctl.word ? W'($signed(div_q[WORD_W-1:0])) : div_q;
            K_REM:    n_res = tail_ctl.word ? W'($signed(div_r[WORD_W-1:0])) : div_r;
            default:  n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res   <= n_res;
            r_taken <= tail_ctl.taken;
            r_ill   <= tail_ctl.illegal;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result       = XLEN'(r_res);
    assign o_rsp.branch_taken = r_taken;
    assign o_rsp.illegal_code = r_ill;

    // illegal items carry nothing else
    a_illegal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.illegal_code |-> o_rsp.result == '0 && !o_rsp.branch_taken)
        else $error("illegal item with non-zero payload");

    // a taken branch is legal and carries a zero result
    a_branch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.branch_taken |-> !o_rsp.illegal_code && o_rsp.result == '0)
        else $error("taken branch with result or illegal flag");

    // input only backs up when the output slot is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> o_rsp.valid && !o_rsp.ready)
        else $error("input stalled without output back-pressure");

    // a frozen pipe keeps its tail item
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && $stable(r_out_valid))
        else $error("pipe moved while stalled");

endmodule

@@ tb/sv/rv64im_integer_alu_checker.sv @@
`timescale 1ns / 1ps
module rv64im_integer_alu_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ria_req_if       i_req,
    ria_rsp_if       i_rsp,
    output int       o_fail_count,
    output int       o_pending
);
    import ria_pkg::*;

    typedef struct packed {
        logic [63:0] result;
        logic        taken;
        logic        illegal;
    } t_alu_out;

    t_alu_out expected_q[$];

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] sx32(input logic [63:0] v);
        sx32 = {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] sdiv_pick(input logic [63:0] a, input logic [63:0] b,
                                              input logic word, input logic want_rem);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0] most_neg;
        sa = word ? sx32(a) : a;
        sb = word ? sx32(b) : b;
        most_neg = word ? 64'hffff_ffff_8000_0000 : SIGN64;
        if (sb == 0)
            sdiv_pick = want_rem ? sa : '1;
        else if (sa == most_neg && sb == '1)
            sdiv_pick = want_rem ? 64'd0 : sa;
        else
            sdiv_pick = want_rem ? sa % sb : sa / sb;
    endfunction

    // code = {funct3, funct7}; word selects 32-bit arithmetic
    function automatic logic alu_op(input logic [9:0] code, input logic [63:0] a,
                                    input logic [63:0] b, input logic word,
                                    output logic [63:0] res);
        logic signed [127:0] prod;
        logic [5:0] sh;
        logic [63:0] sa;
        logic [63:0] sb;
        sa = word ? sx32(a) : a;
        sb = word ? sx32(b) : b;
        sh = word ? {1'b0, b[4:0]} : b[5:0];
        alu_op = 1'b1;
        case (code)
            {F3_ADD, F7_BASE}: res = a + b;
            {F3_ADD, F7_MD}:   res = a * b;
            {F3_ADD, F7_ALT}:  res = a - b;
            {F3_SLL, F7_BASE}: res = a << sh;
            {F3_SLL, F7_MD}: begin
                prod = $signed(sa) * $signed(sb);
                res = word ? prod[63:32] : prod[127:64];
            end
            {F3_SLT, F7_BASE}: res = {63'd0, $signed(sa) < $signed(sb)};
            {F3_XOR, F7_BASE}: res = a ^ b;
            {F3_XOR, F7_MD}:   res = sdiv_pick(a, b, word, 1'b0);
            {F3_SRL, F7_BASE}: res = (word ? {32'd0, a[31:0]} : a) >> sh;
            {F3_SRL, F7_ALT}:  res = $signed(sa) >>> sh;
            {F3_OR, F7_BASE}:  res = a | b;
            {F3_OR, F7_MD}:    res = sdiv_pick(a, b, word, 1'b1);
            {F3_AND, F7_BASE}: res = a & b;
            default: begin
                res = '0;
                alu_op = 1'b0;
            end
        endcase
    endfunction

    function automatic t_alu_out predict_alu(input logic [2:0] kind, input logic [63:0] a,
                                             input logic [63:0] b, input logic [2:0] f3,
                                             input logic [6:0] f7);
        t_alu_out o;
        logic ok;
        logic [6:0] f7e;
        logic [2:0] f3e;
        o = '0;
        ok = 1'b1;
        case (kind)
            REQ_REG: ok = alu_op({f3, f7}, a, b, 1'b0, o.result);
            REQ_IMM: begin
                f7e = (f3 == F3_SLL || f3 == F3_SRL) ? (f7 & F7_IMM_MASK) : F7_BASE;
                ok = alu_op({f3, f7e}, a, b, 1'b0, o.result);
            end
            REQ_WREG, REQ_WIMM: begin
                f3e = f3;
                f7e = f7;
                if (kind == REQ_WIMM) begin
                    if (f3 == F3_ADD) f7e = F7_BASE;
                    else if (f3 != F3_SLL && f3 != F3_SRL) f3e = F3_SLTU;
                end
                case ({f3e, f7e})
                    {F3_ADD, F7_BASE}, {F3_ADD, F7_ALT}, {F3_SLL, F7_BASE},
                    {F3_SRL, F7_BASE}, {F3_SRL, F7_ALT}, {F3_ADD, F7_MD},
                    {F3_XOR, F7_MD}, {F3_OR, F7_MD}:
                        ok = alu_op({f3e, f7e}, a, b, 1'b1, o.result);
                    default: ok = 1'b0;
                endcase
                o.result = sx32(o.result);
            end
            REQ_BRANCH: begin
                case (f3)
                    F3_BEQ:  o.taken = a == b;
                    F3_BNE:  o.taken = a != b;
                    F3_BLT:  o.taken = $signed(a) < $signed(b);
                    F3_BGE:  o.taken = $signed(a) >= $signed(b);
                    F3_BLTU: o.taken = a < b;
                    F3_BGEU: o.taken = a >= b;
                    default: ok = 1'b0;
                endcase
            end
            default: ok = 1'b0;
        endcase
        if (!ok) o = '0;
        o.illegal = !ok;
        return o;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_alu_out exp_o;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready)
                expected_q.push_back(predict_alu(i_req.req_type, i_req.operand_a,
                    i_req.operand_b, i_req.funct3, i_req.funct7));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_o = expected_q.pop_front();
                    if (i_rsp.result !== exp_o.result ||
                        i_rsp.branch_taken !== exp_o.taken ||
                        i_rsp.illegal_code !== exp_o.illegal)
                        o_fail_count <= o_fail_count + 1;
                    if (i_rsp.result !== exp_o.result)
                        $error("result: expected %h actual %h", exp_o.result, i_rsp.result);
                    if (i_rsp.branch_taken !== exp_o.taken)
                        $error("branch_taken: expected %b actual %b", exp_o.taken,
                               i_rsp.branch_taken);
                    if (i_rsp.illegal_code !== exp_o.illegal)
                        $error("illegal_code: expected %b actual %b", exp_o.illegal,
                               i_rsp.illegal_code);
                end
            end
        end
    end
endmodule

@@ tb/sv/rv64im_integer_alu_core_test.sv @@
`timescale 1ns / 1ps
module rv64im_integer_alu_core_test;
    import ria_pkg::*;

    localparam int LATENCY    = 66;
    localparam int STALL_LIMIT = 5000;  // cycles with no handshake at all

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    ria_req_if req_ch ();
    ria_rsp_if rsp_ch ();

    rv64im_integer_alu_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    rv64im_integer_alu_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // receiver: ready changes on the falling edge only
    always @(negedge i_clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one item and hold it until accepted; valid drops between items only for random idle gaps.
    task automatic send_op(input logic [2:0] kind, input logic [63:0] a,
                           input logic [63:0] b, input logic [2:0] f3,
                           input logic [6:0] f7);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        req_ch.funct3    <= f3;
        req_ch.funct7    <= f7;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return {{32{$urandom_range(1) == 1}}, 32'h8000_0000};
            5: return 64'($urandom_range(15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random();
        logic [2:0] kind;
        logic [6:0] f7;
        kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        case ($urandom_range(9))
            0, 1, 2: f7 = F7_BASE;
            3, 4:    f7 = F7_ALT;
            5, 6, 7: f7 = F7_MD;
            default: f7 = 7'($urandom_range(127));
        endcase
        send_op(kind, pick_operand(), pick_operand(), 3'($urandom_range(7)), f7);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_REG;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        req_ch.funct3    = F3_ADD;
        req_ch.funct7    = F7_BASE;
        send_idle_pct    = 12;
        recv_idle_pct    = 51;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner cases of division, shifts, multiply, set-less-than, word add, branches and illegal codes
        send_op(REQ_REG, 64'h8000_0000_0000_0000, '1, F3_XOR, F7_MD);   // div overflow
        send_op(REQ_REG, 64'h8000_0000_0000_0000, '1, F3_OR, F7_MD);    // rem overflow
        send_op(REQ_REG, 64'd1234, 64'd0, F3_XOR, F7_MD);               // div by zero
        send_op(REQ_REG, 64'd1234, 64'd0, F3_OR, F7_MD);                // rem by zero
        send_op(REQ_WREG, 64'h8000_0000, '1, F3_XOR, F7_MD);            // divw overflow
        send_op(REQ_WREG, 64'h5, 64'h1_0000_0000, F3_OR, F7_MD);        // remw by zero
        send_op(REQ_REG, '1, 64'd63, F3_SRL, F7_ALT);
        send_op(REQ_REG, '1, 64'd63, F3_SLL, F7_BASE);
        send_op(REQ_IMM, 64'h8000_0000_0000_0000, 64'h3f, F3_SRL, 7'h21);
        send_op(REQ_WIMM, 64'h8000_0000, 64'h1f, F3_SRL, F7_ALT);
        send_op(REQ_REG, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, F3_SLL, F7_MD);
        send_op(REQ_REG, '1, 64'd1, F3_SLT, F7_BASE);
        send_op(REQ_REG, 64'd1, 64'd1, F3_SLTU, F7_BASE);                // illegal
        send_op(REQ_REG, '1, '1, F3_SLL, 7'h7f);                         // illegal
        send_op(REQ_WIMM, 64'h7fff_ffff, 64'd1, F3_ADD, 7'h55);
        send_op(REQ_WREG, 64'h7fff_ffff, 64'd1, F3_ADD, F7_BASE);
        send_op(REQ_BRANCH, '1, 64'd0, F3_BLT, F7_BASE);
        send_op(REQ_BRANCH, '1, 64'd0, F3_BLTU, F7_BASE);
        send_op(REQ_BRANCH, 64'd7, 64'd7, F3_BEQ, F7_BASE);
        send_op(REQ_BRANCH, 64'd7, 64'd7, F3_BNE, F7_BASE);
        send_op(REQ_BRANCH, 64'd7, 64'd7, F3_BGE, F7_BASE);
        send_op(REQ_BRANCH, 64'd0, '1, F3_BGEU, F7_BASE);
        send_op(REQ_BRANCH, 64'd0, 64'd0, F3_SLT, F7_BASE);              // illegal branch
        send_op(3'd7, '1, '1, F3_AND, F7_BASE);                          // illegal class

        for (int i = 0; i < 2000; i++) begin
            if (i == 700) begin
                send_idle_pct = 51;
                recv_idle_pct = 12;
            end else if (i == 1400) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random();
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
